/* src/mbds_pkg.sv */
// Shared types and constants for the multi-button debounce status block.
// Depends on nothing; imported by mbds_update, the top level and the testbench.
package mbds_pkg;

  // Button status codes.
  localparam logic [1:0] ST_REL_HELD   = 2'd0;
  localparam logic [1:0] ST_JUST_PRESS = 2'd1;
  localparam logic [1:0] ST_PRESS_HELD = 2'd2;
  localparam logic [1:0] ST_JUST_REL   = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_PRESS_THR   = 1'b0;
  localparam logic CFG_RELEASE_THR = 1'b1;

  // One entry of the per-button state memory.
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] press_cnt;
    logic [7:0] release_cnt;
  } mbds_entry_t;

endpackage

/* src/mbds_update.sv */
// Next-state logic for one button entry: counter advance and status move.
// Depends on mbds_pkg for the entry type and the status codes.
module mbds_update
  import mbds_pkg::*;
(
  input  mbds_entry_t cur_i,
  input  logic        pressed_level_i,
  input  logic [7:0]  press_thr_i,
  input  logic [7:0]  release_thr_i,
  output mbds_entry_t nxt_o
);

  logic [7:0] cnt;
  logic [7:0] thr;
  logic [8:0] cnt_inc;
  logic       accepted;
  logic [7:0] cnt_nxt;

  // The counter of the sampled kind advances and saturates at its threshold.
  always_comb begin
    cnt      = pressed_level_i ? cur_i.press_cnt : cur_i.release_cnt;
    thr      = pressed_level_i ? press_thr_i : release_thr_i;
    cnt_inc  = {1'b0, cnt} + 9'd1;
    accepted = (cnt_inc >= {1'b0, thr});
    cnt_nxt  = accepted ? thr : cnt_inc[7:0];
  end

  // The other counter clears, and an accepted sample moves the status.
  always_comb begin
    nxt_o = cur_i;
    if (pressed_level_i) begin
      nxt_o.release_cnt = '0;
      nxt_o.press_cnt   = cnt_nxt;
      if (accepted) begin
        if (cur_i.status == ST_JUST_PRESS) begin
          nxt_o.status = ST_PRESS_HELD;
        end else if (cur_i.status != ST_PRESS_HELD) begin
          nxt_o.status = ST_JUST_PRESS;
        end
      end
    end else begin
      nxt_o.press_cnt   = '0;
      nxt_o.release_cnt = cnt_nxt;
      if (accepted) begin
        if (cur_i.status == ST_JUST_REL) begin
          nxt_o.status = ST_REL_HELD;
        end else if (cur_i.status != ST_REL_HELD) begin
          nxt_o.status = ST_JUST_REL;
        end
      end
    end
  end

endmodule

/* src/multi_button_debounce_status_core.sv */
// Top level of the multi-button debounce status block: state memory, pipeline, ports.
// Depends on mbds_pkg and mbds_update.
//
// Usage: each input item carries one sample (button_index_i, pressed_level_i) and
// gives exactly one result item (button_echo_o, status_code_o) with that button's
// status after the update. Both channels use valid/ready. Samples for an index not
// below NUM_BUTTONS change nothing and report status 0.
// The user writes the thresholds through cfg_we_i/cfg_idx_i/cfg_wdata_i only while
// idle; the block does not enforce this. Counters and status per button live in a
// synchronous memory with a registered read. An item reads its entry when accepted,
// waits in the update stage and, when that stage advances, is updated and written back,
// and its result lands in the output register at that same edge. One item per cycle
// is sustained while out_ready_i is high; a hit on the last write is fed from a bypass.
// When the receiver stalls, the output register and the update stage both fill,
// then in_ready_o drops; nothing is lost. Reset (rst_ni low) restores thresholds
// of 3 and clears per-entry valid flags so every button reads as released-held
// with zero counters; no clearing pass is needed.
module multi_button_debounce_status_core
  import mbds_pkg::*;
#(
  parameter int NUM_BUTTONS = 3
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] button_index_i,
  input  logic       pressed_level_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] button_echo_o,
  output logic [1:0] status_code_o,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_wdata_i
);

  localparam int AddrW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  // Configuration registers.
  logic [7:0] press_thr_q;
  logic [7:0] release_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_thr_q   <= 8'd3;
      release_thr_q <= 8'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PRESS_THR:   press_thr_q   <= cfg_wdata_i;
        CFG_RELEASE_THR: release_thr_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake and flow control.
  logic             s1_vld_q;
  logic             s1_adv;
  logic             in_acc;
  logic             out_vld_q;
  logic [31:0]      idx_ext;
  logic             in_range;
  logic [AddrW-1:0] in_addr;

  assign s1_adv     = !out_vld_q || out_ready_i;
  assign in_ready_o = !s1_vld_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;
  assign idx_ext    = 32'(button_index_i);
  assign in_range   = (idx_ext < 32'(NUM_BUTTONS));
  assign in_addr    = idx_ext[AddrW-1:0];

  // State memory with per-entry valid flags; an unwritten entry reads as reset.
  mbds_entry_t            mem_q [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] ent_vld_q;
  mbds_entry_t            rdata_q;
  logic                   rd_ent_vld_q;
  logic                   mem_we;
  mbds_entry_t            wdata;
  logic [AddrW-1:0]       s1_addr_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && in_range) begin
      rdata_q <= mem_q[in_addr];
    end
    if (mem_we) begin
      mem_q[s1_addr_q] <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q    <= '0;
      rd_ent_vld_q <= 1'b0;
    end else begin
      if (in_acc && in_range) begin
        rd_ent_vld_q <= ent_vld_q[in_addr];
      end
      if (mem_we) begin
        ent_vld_q[s1_addr_q] <= 1'b1;
      end
    end
  end

  // Update stage registers.
  logic       s1_rng_q;
  logic [1:0] s1_idx_q;
  logic       s1_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_rng_q   <= in_range;
      s1_idx_q   <= button_index_i;
      s1_level_q <= pressed_level_i;
      s1_addr_q  <= in_addr;
    end
  end

  // Bypass of the last write, which the memory read may have missed.
  logic             wr_vld_q;
  logic [AddrW-1:0] wr_addr_q;
  mbds_entry_t      wr_data_q;
  logic             fwd_hit;
  mbds_entry_t      cur_ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_vld_q <= 1'b0;
    end else if (mem_we) begin
      wr_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      wr_addr_q <= s1_addr_q;
      wr_data_q <= wdata;
    end
  end

  assign fwd_hit = wr_vld_q && (wr_addr_q == s1_addr_q);

  always_comb begin
    if (fwd_hit) begin
      cur_ent = wr_data_q;
    end else if (rd_ent_vld_q) begin
      cur_ent = rdata_q;
    end else begin
      cur_ent = '0;
    end
  end

  // Counter and status update.
  mbds_update u_update (
    .cur_i          (cur_ent),
    .pressed_level_i(s1_level_q),
    .press_thr_i    (press_thr_q),
    .release_thr_i  (release_thr_q),
    .nxt_o          (wdata)
  );

  assign mem_we = s1_vld_q && s1_adv && s1_rng_q;

  // Output register.
  logic [1:0] out_echo_q;
  logic [1:0] out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q && s1_adv) begin
      out_echo_q   <= s1_idx_q;
      out_status_q <= s1_rng_q ? wdata.status : ST_REL_HELD;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign button_echo_o = out_echo_q;
  assign status_code_o = out_status_q;

  // Checks on the pipeline and the update.
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_vld_q && out_vld_q))
    else $error("input stalled while a pipeline stage is free");

  a_adv_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && s1_adv) |=> out_vld_q)
    else $error("item left the update stage but no result is valid");

  a_rel_clr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && !s1_level_q) |-> (wdata.press_cnt == 8'd0))
    else $error("press counter kept for a released sample");

  a_we_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (s1_vld_q && s1_rng_q))
    else $error("state written for an out-of-range button");

endmodule

/* bench/multi_button_debounce_status_core_tb.sv */
// Self-checking testbench for multi_button_debounce_status_core: directed samples, then
// random debounce runs at several thresholds, checked by a local predictor or the table.
// Depends on mbds_pkg and the RTL of the block; needs nothing else.
module multi_button_debounce_status_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mbds_pkg::*;

  localparam int NUM_BTN      = 3;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 3000;
  localparam int SETTLE       = 4;
  localparam int PLAN_LEN     = 26;
  localparam int MAX_PRINTED  = 100;

  // One result item: which button and its status.
  typedef struct {
    logic [1:0] echo;
    logic [1:0] status;
  } status_result_t;

  // A status typed into the directed table, or none.
  typedef struct {
    bit         pinned;
    logic [1:0] status;
  } typed_status_t;

  typedef enum logic {DO_SAMPLE, DO_WRITE} plan_op_e;

  typedef struct {
    plan_op_e   op;
    logic [1:0] btn;
    logic       lvl;
    logic       cfg_sel;
    logic [7:0] value;
    bit         pinned;
    logic [1:0] status;
  } plan_row_t;

  // Directed part: basic press/release cycle at the reset thresholds, an index past the
  // last button, the threshold of one and of zero, and a threshold lowered under a count.
  plan_row_t directed_plan [PLAN_LEN] = '{
    '{DO_SAMPLE, 2'd0, 1'b1, CFG_PRESS_THR,   8'd0,   1'b1, ST_REL_HELD},
    '{DO_SAMPLE, 2'd0, 1'b1, CFG_PRESS_THR,   8'd0,   1'b1, ST_REL_HELD},
    '{DO_SAMPLE, 2'd0, 1'b1, CFG_PRESS_THR,   8'd0,   1'b1, ST_JUST_PRESS},
    '{DO_SAMPLE, 2'd0, 1'b1, CFG_PRESS_THR,   8'd0,   1'b1, ST_PRESS_HELD},
    '{DO_SAMPLE, 2'd0, 1'b0, CFG_PRESS_THR,   8'd0,   1'b1, ST_PRESS_HELD},
    '{DO_SAMPLE, 2'd0, 1'b0, CFG_PRESS_THR,   8'd0,   1'b1, ST_PRESS_HELD},
    '{DO_SAMPLE, 2'd0, 1'b0, CFG_PRESS_THR,   8'd0,   1'b1, ST_JUST_REL},
    '{DO_SAMPLE, 2'd0, 1'b0, CFG_PRESS_THR,   8'd0,   1'b1, ST_REL_HELD},
    '{DO_SAMPLE, 2'd3, 1'b1, CFG_PRESS_THR,   8'd0,   1'b1, ST_REL_HELD},
    '{DO_SAMPLE, 2'd3, 1'b0, CFG_PRESS_THR,   8'd0,   1'b1, ST_REL_HELD},
    '{DO_WRITE,  2'd0, 1'b0, CFG_PRESS_THR,   8'd1,   1'b0, ST_REL_HELD},
    '{DO_SAMPLE, 2'd1, 1'b1, CFG_PRESS_THR,   8'd0,   1'b1, ST_JUST_PRESS},
    '{DO_SAMPLE, 2'd1, 1'b1, CFG_PRESS_THR,   8'd0,   1'b1, ST_PRESS_HELD},
    '{DO_WRITE,  2'd0, 1'b0, CFG_RELEASE_THR, 8'd0,   1'b0, ST_REL_HELD},
    '{DO_SAMPLE, 2'd1, 1'b0, CFG_PRESS_THR,   8'd0,   1'b1, ST_JUST_REL},
    '{DO_SAMPLE, 2'd1, 1'b0, CFG_PRESS_THR,   8'd0,   1'b1, ST_REL_HELD},
    '{DO_WRITE,  2'd0, 1'b0, CFG_PRESS_THR,   8'd255, 1'b0, ST_REL_HELD},
    '{DO_SAMPLE, 2'd2, 1'b1, CFG_PRESS_THR,   8'd0,   1'b0, ST_REL_HELD},
    '{DO_SAMPLE, 2'd2, 1'b1, CFG_PRESS_THR,   8'd0,   1'b0, ST_REL_HELD},
    '{DO_SAMPLE, 2'd2, 1'b1, CFG_PRESS_THR,   8'd0,   1'b0, ST_REL_HELD},
    '{DO_SAMPLE, 2'd2, 1'b1, CFG_PRESS_THR,   8'd0,   1'b0, ST_REL_HELD},
    '{DO_WRITE,  2'd0, 1'b0, CFG_PRESS_THR,   8'd2,   1'b0, ST_REL_HELD},
    '{DO_SAMPLE, 2'd2, 1'b1, CFG_PRESS_THR,   8'd0,   1'b0, ST_REL_HELD},
    '{DO_WRITE,  2'd0, 1'b0, CFG_PRESS_THR,   8'd0,   1'b0, ST_REL_HELD},
    '{DO_SAMPLE, 2'd2, 1'b1, CFG_PRESS_THR,   8'd0,   1'b0, ST_REL_HELD},
    '{DO_SAMPLE, 2'd2, 1'b0, CFG_PRESS_THR,   8'd0,   1'b0, ST_REL_HELD}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] button_index_i;
  logic       pressed_level_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [1:0] button_echo_o;
  logic [1:0] status_code_o;
  logic       cfg_we_i;
  logic       cfg_idx_i;
  logic [7:0] cfg_wdata_i;

  // Predictor state: thresholds and per-button counters and status.
  logic [7:0] press_thr_m;
  logic [7:0] release_thr_m;
  logic [7:0] press_cnt_m   [NUM_BTN];
  logic [7:0] release_cnt_m [NUM_BTN];
  logic [1:0] status_m      [NUM_BTN];

  status_result_t pending_status_q [$];
  typed_status_t  typed_status_q [$];
  int             error_count = 0;
  int             quiet_cycles = 0;
  int             send_idle_pct = 0;
  int             recv_idle_pct = 0;
  logic           hold_req;

  multi_button_debounce_status_core #(
    .NUM_BUTTONS(NUM_BTN)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .button_index_i (button_index_i),
    .pressed_level_i(pressed_level_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .button_echo_o  (button_echo_o),
    .status_code_o  (status_code_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Advance a counter toward its threshold and clamp it there; true when the sample counts.
  function automatic bit bump_count(inout logic [7:0] cnt, input logic [7:0] thr);
    logic [8:0] nxt;
    nxt = {1'b0, cnt} + 9'd1;
    if (nxt >= {1'b0, thr}) begin
      cnt = thr;
      return 1'b1;
    end
    cnt = nxt[7:0];
    return 1'b0;
  endfunction

  // Apply one sample to the predictor and return the button's new status.
  function automatic logic [1:0] predict_status(input logic [1:0] btn, input logic lvl);
    logic [1:0] st;
    if (btn >= NUM_BTN) return ST_REL_HELD;
    st = status_m[btn];
    if (lvl) begin
      release_cnt_m[btn] = '0;
      if (bump_count(press_cnt_m[btn], press_thr_m)) begin
        if (st == ST_JUST_PRESS) st = ST_PRESS_HELD;
        else if (st != ST_PRESS_HELD) st = ST_JUST_PRESS;
      end
    end else begin
      press_cnt_m[btn] = '0;
      if (bump_count(release_cnt_m[btn], release_thr_m)) begin
        if (st == ST_JUST_REL) st = ST_REL_HELD;
        else if (st != ST_REL_HELD) st = ST_JUST_REL;
      end
    end
    status_m[btn] = st;
    return st;
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTED) $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Offer one sample, after a random gap, and hold it until the block takes it.
  task automatic send_sample(input logic [1:0] btn, input logic lvl, input bit pinned,
                             input logic [1:0] status);
    typed_status_t typed;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    typed.pinned = pinned;
    typed.status = status;
    typed_status_q.push_back(typed);
    in_valid_i      <= 1'b1;
    button_index_i  <= btn;
    pressed_level_i <= lvl;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Stop offering items, wait for every pending result, then let the pipeline drain.
  // The first edge lets the checker record an item accepted at the previous edge.
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_status_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic cfg_sel, input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= cfg_sel;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (cfg_sel == CFG_PRESS_THR) press_thr_m = value;
    else release_thr_m = value;
    @(posedge clk_i);
  endtask

  // Mostly small thresholds so that runs reach acceptance often; zero now and then.
  function automatic logic [7:0] pick_threshold();
    if ($urandom_range(9) == 0) return 8'd0;
    return 8'($urandom_range(1, 6));
  endfunction

  // Random runs of one level on one button, long enough to cross the threshold most of
  // the time, with samples for other buttons and out-of-range indexes mixed in.
  task automatic run_segment(input int n_items);
    int         sent;
    int         len;
    logic [1:0] btn;
    logic       lvl;
    logic [7:0] thr;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 15) begin
        btn = 2'($urandom_range(3));
        lvl = 1'($urandom_range(1));
        send_sample(btn, lvl, 1'b0, ST_REL_HELD);
        if (btn < NUM_BTN) sent++;
      end else begin
        btn = 2'($urandom_range(NUM_BTN - 1));
        lvl = 1'($urandom_range(1));
        thr = lvl ? press_thr_m : release_thr_m;
        len = $urandom_range(1, int'(thr) + 2);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(99) < 10) begin
            send_sample(2'($urandom_range(3)), 1'($urandom_range(1)), 1'b0, ST_REL_HELD);
          end
          send_sample(btn, lvl, 1'b0, ST_REL_HELD);
          sent++;
        end
      end
    end
  endtask

  // Receiver: random stalls, and one long hold-off when asked for.
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req    <= 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_ready_i <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Predict on every accepted sample, check every accepted result, and watch for a hang.
  always @(posedge clk_i) begin
    status_result_t predicted;
    status_result_t want;
    typed_status_t  typed;
    bit             moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_valid_i && in_ready_o) begin
        moved            = 1'b1;
        predicted.echo   = button_index_i;
        predicted.status = predict_status(button_index_i, pressed_level_i);
        if (typed_status_q.size() != 0) begin
          typed = typed_status_q.pop_front();
          if (typed.pinned) predicted.status = typed.status;
        end
        pending_status_q.push_back(predicted);
      end
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        if (pending_status_q.size() == 0) begin
          report_mismatch($sformatf("result button %0d status %0d with nothing pending",
                                    button_echo_o, status_code_o));
        end else begin
          want = pending_status_q.pop_front();
          if (button_echo_o !== want.echo)
            report_mismatch($sformatf("button_echo got %0d expected %0d",
                                      button_echo_o, want.echo));
          if (status_code_o !== want.status)
            report_mismatch($sformatf("status_code of button %0d got %0d expected %0d",
                                      want.echo, status_code_o, want.status));
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed table, random phases, extreme thresholds.
  initial begin
    logic [1:0] btn;
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    button_index_i  <= '0;
    pressed_level_i <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= CFG_PRESS_THR;
    cfg_wdata_i     <= '0;
    hold_req        <= 1'b0;
    press_thr_m   = 8'd3;
    release_thr_m = 8'd3;
    for (int b = 0; b < NUM_BTN; b++) begin
      press_cnt_m[b]   = '0;
      release_cnt_m[b] = '0;
      status_m[b]      = ST_REL_HELD;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 38;
    recv_idle_pct = 48;
    foreach (directed_plan[i]) begin
      if (directed_plan[i].op == DO_WRITE) begin
        settle_idle();
        write_threshold(directed_plan[i].cfg_sel, directed_plan[i].value);
      end else begin
        send_sample(directed_plan[i].btn, directed_plan[i].lvl, directed_plan[i].pinned,
                    directed_plan[i].status);
      end
    end

    // Random phases: receiver-heavy idling, sender-heavy idling, then none.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 48 : 0;
      recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 38 : 0;
      for (int seg = 0; seg < 3; seg++) begin
        settle_idle();
        write_threshold(CFG_PRESS_THR, pick_threshold());
        write_threshold(CFG_RELEASE_THR, pick_threshold());
        // Long receiver hold-off while samples keep coming, so the input backs up.
        if (phase == 2 && seg == 0) hold_req <= 1'b1;
        run_segment(16);
      end
    end

    // Largest thresholds: one full press run and one full release run on one button.
    settle_idle();
    write_threshold(CFG_PRESS_THR, 8'd255);
    write_threshold(CFG_RELEASE_THR, 8'd255);
    btn = 2'($urandom_range(NUM_BTN - 1));
    repeat (256) send_sample(btn, 1'b1, 1'b0, ST_REL_HELD);
    repeat (256) send_sample(btn, 1'b0, 1'b0, ST_REL_HELD);

    // Smallest nonzero thresholds with idling on both sides.
    settle_idle();
    send_idle_pct = 38;
    recv_idle_pct = 48;
    write_threshold(CFG_PRESS_THR, 8'd1);
    write_threshold(CFG_RELEASE_THR, 8'd1);
    run_segment(20);

    settle_idle();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
src/mbds_pkg.sv
src/mbds_update.sv
src/multi_button_debounce_status_core.sv
bench/multi_button_debounce_status_core_tb.sv
